>>> sv/utm_pkg.sv
// ----------------------------------------------------------------------------
// Usage time meter package
// Shared widths, time constants, codes and control structs of the meter.
// ----------------------------------------------------------------------------
package utm_pkg;

   // field widths
   localparam int CMD_W        = 2;
   localparam int TYPE_W       = 4;
   localparam int SECS_W       = 31;
   localparam int DAYS_W       = 15;
   localparam int PART_W       = 8;
   localparam int SHOWN_DAYS_W = 15;
   localparam int SHOWN_HRS_W  = 20;
   localparam int SHOWN_MS_W   = 6;
   localparam int LEVEL_W      = 2;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 15;
   localparam int THR_W        = 32;

   // time constants
   localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
   localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
   localparam logic [31:0] SECS_PER_MIN  = 32'd60;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_CLEAR  = 2'd1,
      CMD_PRESET = 2'd2
   } cmd_type;

   typedef enum logic [LEVEL_W-1:0] {
      LEVEL_NORMAL = 2'd0,
      LEVEL_WARN   = 2'd1,
      LEVEL_ALARM  = 2'd2
   } level_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_METER_TYPE     = 3'd0,
      CSR_HOUR_MODE      = 3'd1,
      CSR_MONITOR_ENABLE = 3'd2,
      CSR_WARN_DAYS      = 3'd3,
      CSR_WARN_HOURS     = 3'd4,
      CSR_ALARM_DAYS     = 3'd5,
      CSR_ALARM_HOURS    = 3'd6
   } csr_idx_type;

   // settings seen by the datapath, thresholds already in seconds
   typedef struct packed {
      logic [TYPE_W-1:0] meter_type;
      logic              hour_mode;
      logic              monitor_enable;
      logic [THR_W-1:0]  warn_thr;
      logic [THR_W-1:0]  alarm_thr;
   } cfg_type;

   // count after one item, handed from the counter to the display pipeline
   typedef struct packed {
      logic              valid;
      logic [SECS_W-1:0] count;
      logic              update;
      logic              check;
   } snap_type;

endpackage

>>> sv/utm_req_if.sv
// ----------------------------------------------------------------------------
// Meter command channel
// Valid/ready channel carrying one meter command item.
// ----------------------------------------------------------------------------
interface utm_req_if;
   import utm_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [TYPE_W-1:0]   item_type;
   logic [SECS_W-1:0]   amount_seconds;
   logic [DAYS_W-1:0]   load_days;
   logic [PART_W-1:0]   load_hours;
   logic [PART_W-1:0]   load_minutes;
   logic [PART_W-1:0]   load_seconds;

   modport source (
      output valid, command, item_type, amount_seconds,
             load_days, load_hours, load_minutes, load_seconds,
      input  ready
   );

   modport sink (
      input  valid, command, item_type, amount_seconds,
             load_days, load_hours, load_minutes, load_seconds,
      output ready
   );

endinterface

>>> sv/utm_rsp_if.sv
// ----------------------------------------------------------------------------
// Meter result channel
// Valid/ready channel carrying the shown time and threshold level.
// ----------------------------------------------------------------------------
interface utm_rsp_if;
   import utm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [SHOWN_DAYS_W-1:0] shown_days;
   logic [SHOWN_HRS_W-1:0]  shown_hours;
   logic [SHOWN_MS_W-1:0]   shown_minutes;
   logic [SHOWN_MS_W-1:0]   shown_seconds;
   logic                    display_update;
   logic [LEVEL_W-1:0]      level;

   modport source (
      output valid, shown_days, shown_hours, shown_minutes, shown_seconds,
             display_update, level,
      input  ready
   );

   modport sink (
      input  valid, shown_days, shown_hours, shown_minutes, shown_seconds,
             display_update, level,
      output ready
   );

endinterface

>>> sv/utm_csr_if.sv
// ----------------------------------------------------------------------------
// Meter register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface utm_csr_if;
   import utm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);

endinterface

>>> sv/utm_csr.sv
// ----------------------------------------------------------------------------
// Meter settings registers
// Holds the settings and keeps both thresholds converted to seconds.
// ----------------------------------------------------------------------------
module utm_csr (
   input  logic            clock,
   input  logic            reset,
   utm_csr_if.sink         csr_chan,
   output utm_pkg::cfg_type cfg
);
   import utm_pkg::*;

   logic [TYPE_W-1:0] meter_type_ff;
   logic              hour_mode_ff;
   logic              monitor_enable_ff;
   logic [DAYS_W-1:0] warn_days_ff;
   logic [PART_W-1:0] warn_hours_ff;
   logic [DAYS_W-1:0] alarm_days_ff;
   logic [PART_W-1:0] alarm_hours_ff;
   logic [THR_W-1:0]  warn_thr_ff;
   logic [THR_W-1:0]  warn_thr_in;
   logic [THR_W-1:0]  alarm_thr_ff;
   logic [THR_W-1:0]  alarm_thr_in;

   // writes are always taken
   assign csr_chan.ready = 1'b1;

   // store a written register, ignore indexes past the list
   always_ff @(posedge clock) begin
      if (reset) begin
         meter_type_ff     <= '0;
         hour_mode_ff      <= 1'b0;
         monitor_enable_ff <= 1'b0;
         warn_days_ff      <= '0;
         warn_hours_ff     <= '0;
         alarm_days_ff     <= '0;
         alarm_hours_ff    <= '0;
      end else if (csr_chan.valid) begin
         case (csr_idx_type'(csr_chan.index))
            CSR_METER_TYPE:     meter_type_ff     <= csr_chan.data[TYPE_W-1:0];
            CSR_HOUR_MODE:      hour_mode_ff      <= csr_chan.data[0];
            CSR_MONITOR_ENABLE: monitor_enable_ff <= csr_chan.data[0];
            CSR_WARN_DAYS:      warn_days_ff      <= csr_chan.data[DAYS_W-1:0];
            CSR_WARN_HOURS:     warn_hours_ff     <= csr_chan.data[PART_W-1:0];
            CSR_ALARM_DAYS:     alarm_days_ff     <= csr_chan.data[DAYS_W-1:0];
            CSR_ALARM_HOURS:    alarm_hours_ff    <= csr_chan.data[PART_W-1:0];
            default: ;
         endcase
      end
   end

   // convert thresholds to seconds; the value never exceeds 32 bits
   assign warn_thr_in  = THR_W'(warn_days_ff) * SECS_PER_DAY
                       + THR_W'(warn_hours_ff) * SECS_PER_HOUR;
   assign alarm_thr_in = THR_W'(alarm_days_ff) * SECS_PER_DAY
                       + THR_W'(alarm_hours_ff) * SECS_PER_HOUR;

   always_ff @(posedge clock) begin
      if (reset) begin
         warn_thr_ff  <= '0;
         alarm_thr_ff <= '0;
      end else begin
         warn_thr_ff  <= warn_thr_in;
         alarm_thr_ff <= alarm_thr_in;
      end
   end

   assign cfg.meter_type     = meter_type_ff;
   assign cfg.hour_mode      = hour_mode_ff;
   assign cfg.monitor_enable = monitor_enable_ff;
   assign cfg.warn_thr       = warn_thr_ff;
   assign cfg.alarm_thr      = alarm_thr_ff;

endmodule

>>> sv/utm_front.sv
// ----------------------------------------------------------------------------
// Meter command front end
// Registers each command item and applies it to the running second count.
// ----------------------------------------------------------------------------
module utm_front (
   input  logic              clock,
   input  logic              reset,
   utm_req_if.sink           req_chan,
   input  utm_pkg::cfg_type  cfg,
   output utm_pkg::snap_type snap,
   input  logic              snap_ready
);
   import utm_pkg::*;

   typedef struct packed {
      cmd_type           cmd;
      logic              match;
      logic [SECS_W-1:0] amount;
      logic [SECS_W-1:0] preset;
   } entry_type;

   entry_type         in_ff;
   entry_type         in_in;
   logic              in_vld_ff;
   logic              in_vld_in;
   logic              in_rdy;
   logic [31:0]       preset_total;

   logic              snap_vld_ff;
   logic              snap_vld_in;
   logic              snap_rdy;
   logic [SECS_W-1:0] snap_count_ff;
   logic              snap_update_ff;
   logic              snap_check_ff;

   logic [SECS_W-1:0] count_ff;
   logic [SECS_W-1:0] count_in;
   logic [SECS_W:0]   sum;
   logic              update;
   logic              check;
   logic              adv;

   // handshake: each stage takes a new item when empty or draining
   assign snap_rdy       = !snap_vld_ff || snap_ready;
   assign in_rdy         = !in_vld_ff || snap_rdy;
   assign adv            = in_vld_ff && snap_rdy;
   assign req_chan.ready = in_rdy;
   assign in_vld_in      = in_rdy ? req_chan.valid : in_vld_ff;
   assign snap_vld_in    = snap_rdy ? in_vld_ff : snap_vld_ff;

   // decode the item and fold the preset parts into seconds on the way in
   always_comb begin
      preset_total = 32'(req_chan.load_days) * SECS_PER_DAY
                   + 32'(req_chan.load_hours) * SECS_PER_HOUR
                   + 32'(req_chan.load_minutes) * SECS_PER_MIN
                   + 32'(req_chan.load_seconds);
      in_in.cmd    = cmd_type'(req_chan.command);
      in_in.match  = (req_chan.item_type == cfg.meter_type);
      in_in.amount = req_chan.amount_seconds;
      in_in.preset = preset_total[31] ? '0 : preset_total[SECS_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_rdy) begin
         in_ff <= in_in;
      end
   end

   // apply the command to the count; an overflowing sum clears it
   always_comb begin
      sum      = {1'b0, count_ff} + {1'b0, in_ff.amount};
      count_in = count_ff;
      update   = 1'b0;
      check    = 1'b0;
      case (in_ff.cmd)
         CMD_ADD: begin
            if (in_ff.match) begin
               if (in_ff.amount != '0) begin
                  count_in = sum[SECS_W] ? '0 : sum[SECS_W-1:0];
                  update   = 1'b1;
               end
               check = cfg.monitor_enable;
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
            update   = 1'b1;
         end
         CMD_PRESET: begin
            count_in = in_ff.preset;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         snap_vld_ff <= 1'b0;
      end else begin
         snap_vld_ff <= snap_vld_in;
         if (adv) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         snap_count_ff  <= count_in;
         snap_update_ff <= update;
         snap_check_ff  <= check;
      end
   end

   assign snap.valid  = snap_vld_ff;
   assign snap.count  = snap_count_ff;
   assign snap.update = snap_update_ff;
   assign snap.check  = snap_check_ff;

`ifndef SYNTH
   a_count_holds_when_idle: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(count_ff))
      else $error("count changed without an item");

   a_snap_tracks_count: assert property (@(posedge clock) disable iff (reset)
      adv |=> (snap_count_ff == count_ff))
      else $error("snapshot differs from count");

   a_clear_zeroes_count: assert property (@(posedge clock) disable iff (reset)
      (adv && in_ff.cmd == CMD_CLEAR) |=> (count_ff == '0 && snap_update_ff))
      else $error("clear did not zero the count");
`endif

endmodule

>>> sv/utm_show.sv
// ----------------------------------------------------------------------------
// Meter display pipeline
// Splits a second count into days, hours, minutes and seconds and grades
// it against the thresholds; the last stage is the result register.
// ----------------------------------------------------------------------------
module utm_show (
   input  logic              clock,
   input  logic              reset,
   input  utm_pkg::snap_type snap,
   output logic              snap_ready,
   input  utm_pkg::cfg_type  cfg,
   utm_rsp_if.source         rsp_chan
);
   import utm_pkg::*;

   localparam int STAGES = 6;
   localparam logic [19:0] HOURS_PER_DAY = 20'd24;

   // reciprocals for exact division of bounded values by odd factors:
   // day = (count >> 7) / 675, hour = (rest >> 4) / 225, min = (rest >> 2) / 15
   localparam longint unsigned DAY_RECIP_FULL = ((64'd1 << 34) + 64'd674) / 64'd675;
   localparam longint unsigned HR_RECIP_FULL  = ((64'd1 << 21) + 64'd224) / 64'd225;
   localparam longint unsigned MIN_RECIP_FULL = ((64'd1 << 14) + 64'd14) / 64'd15;
   localparam logic [24:0] DAY_RECIP = 25'(DAY_RECIP_FULL);
   localparam logic [13:0] HR_RECIP  = 14'(HR_RECIP_FULL);
   localparam logic [10:0] MIN_RECIP = 11'(MIN_RECIP_FULL);

   typedef struct packed {
      logic        update;
      level_type   level;
   } tag_type;

   typedef struct packed {
      tag_type           tag;
      logic [SECS_W-1:0] count;
      logic [14:0]       days;
   } s1_type;

   typedef struct packed {
      tag_type     tag;
      logic [14:0] days;
      logic [16:0] restd;
   } s2_type;

   typedef struct packed {
      tag_type     tag;
      logic [14:0] days;
      logic [16:0] restd;
      logic [4:0]  hr;
   } s3_type;

   typedef struct packed {
      tag_type     tag;
      logic [14:0] days;
      logic [19:0] hours;
      logic [11:0] resth;
   } s4_type;

   typedef struct packed {
      tag_type     tag;
      logic [14:0] days;
      logic [19:0] hours;
      logic [11:0] resth;
      logic [5:0]  mins;
   } s5_type;

   typedef struct packed {
      tag_type     tag;
      logic [14:0] days;
      logic [19:0] hours;
      logic [5:0]  mins;
      logic [5:0]  secs;
   } s6_type;

   logic [STAGES-1:0] vld_ff;
   logic [STAGES-1:0] vld_in;
   logic [STAGES-1:0] rdy;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   s4_type s4_ff, s4_in;
   s5_type s5_ff, s5_in;
   s6_type s6_ff, s6_in;

   logic [48:0] day_prod;
   logic [26:0] hr_prod;
   logic [20:0] min_prod;
   level_type   level;

   // stage handshake: a stage loads when empty or when its item moves on
   always_comb begin
      rdy[STAGES-1] = !vld_ff[STAGES-1] || rsp_chan.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
      vld_in[0] = rdy[0] ? snap.valid : vld_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         vld_in[k] = rdy[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   assign snap_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // grade the count and take whole days
   always_comb begin
      level = LEVEL_NORMAL;
      if (snap.check && cfg.alarm_thr != '0 && {1'b0, snap.count} > cfg.alarm_thr) begin
         level = LEVEL_ALARM;
      end else if (snap.check && cfg.warn_thr != '0
                   && {1'b0, snap.count} > cfg.warn_thr) begin
         level = LEVEL_WARN;
      end
      day_prod         = 49'(snap.count[SECS_W-1:7]) * 49'(DAY_RECIP);
      s1_in.tag.update = snap.update;
      s1_in.tag.level  = level;
      s1_in.count      = snap.count;
      s1_in.days       = day_prod[48:34];
   end

   // remainder within the day
   always_comb begin
      s2_in.tag   = s1_ff.tag;
      s2_in.days  = s1_ff.days;
      s2_in.restd = 17'(s1_ff.count - SECS_W'(s1_ff.days) * SECS_W'(SECS_PER_DAY));
   end

   // hour within the day
   always_comb begin
      hr_prod     = 27'(s2_ff.restd[16:4]) * 27'(HR_RECIP);
      s3_in.tag   = s2_ff.tag;
      s3_in.days  = s2_ff.days;
      s3_in.restd = s2_ff.restd;
      s3_in.hr    = hr_prod[25:21];
   end

   // remainder within the hour; fold days into hours in hour mode
   always_comb begin
      s4_in.tag   = s3_ff.tag;
      s4_in.resth = 12'(s3_ff.restd - 17'(s3_ff.hr) * 17'(SECS_PER_HOUR));
      if (cfg.hour_mode) begin
         s4_in.days  = '0;
         s4_in.hours = 20'(s3_ff.days) * HOURS_PER_DAY + 20'(s3_ff.hr);
      end else begin
         s4_in.days  = s3_ff.days;
         s4_in.hours = 20'(s3_ff.hr);
      end
   end

   // minute within the hour
   always_comb begin
      min_prod    = 21'(s4_ff.resth[11:2]) * 21'(MIN_RECIP);
      s5_in.tag   = s4_ff.tag;
      s5_in.days  = s4_ff.days;
      s5_in.hours = s4_ff.hours;
      s5_in.resth = s4_ff.resth;
      s5_in.mins  = min_prod[19:14];
   end

   // second within the minute
   always_comb begin
      s6_in.tag   = s5_ff.tag;
      s6_in.days  = s5_ff.days;
      s6_in.hours = s5_ff.hours;
      s6_in.mins  = s5_ff.mins;
      s6_in.secs  = 6'(s5_ff.resth - 12'(s5_ff.mins) * 12'(SECS_PER_MIN));
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) s1_ff <= s1_in;
      if (rdy[1]) s2_ff <= s2_in;
      if (rdy[2]) s3_ff <= s3_in;
      if (rdy[3]) s4_ff <= s4_in;
      if (rdy[4]) s5_ff <= s5_in;
      if (rdy[5]) s6_ff <= s6_in;
   end

   assign rsp_chan.valid          = vld_ff[STAGES-1];
   assign rsp_chan.shown_days     = s6_ff.days;
   assign rsp_chan.shown_hours    = s6_ff.hours;
   assign rsp_chan.shown_minutes  = s6_ff.mins;
   assign rsp_chan.shown_seconds  = s6_ff.secs;
   assign rsp_chan.display_update = s6_ff.tag.update;
   assign rsp_chan.level          = s6_ff.tag.level;

`ifndef SYNTH
   a_day_rest_in_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] |-> (s2_ff.restd < 17'(SECS_PER_DAY)))
      else $error("day remainder out of range");

   a_hour_rest_in_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (s4_ff.resth < 12'(SECS_PER_HOUR)))
      else $error("hour remainder out of range");

   a_min_sec_in_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[5] |-> (s6_ff.mins < 6'(SECS_PER_MIN) && s6_ff.secs < 6'(SECS_PER_MIN)))
      else $error("minute or second out of range");
`endif

endmodule

>>> sv/usage_time_meter_with_thresholds_unit.sv
// ----------------------------------------------------------------------------
// Usage time meter with thresholds
// Running usage count in seconds with add, clear and preset commands,
// a day/hour/minute/second display and warning and alarm grading.
//
//   channel    direction  handshake      carries
//   req_chan   in         valid/ready    command, type, amount, preset parts
//   rsp_chan   out        valid/ready    shown time, display update, level
//   csr_chan   in         valid/ready    register index and write data
//
// One item is taken every cycle unless a stalled rsp_chan has filled the
// pipeline; its result passes the input register, the count register and
// six display stages. Reset clears count, settings and all stage valids.
// A stalled result holds only its own stage; upstream stages keep filling
// until the pipeline is full, then req_chan.ready drops.
// Writes are stored when taken; the thresholds in seconds are registered again.
// ----------------------------------------------------------------------------
module usage_time_meter_with_thresholds_unit (
   input  logic       clock,
   input  logic       reset,
   utm_req_if.sink    req_chan,
   utm_rsp_if.source  rsp_chan,
   utm_csr_if.sink    csr_chan
);
   import utm_pkg::*;

   cfg_type  cfg;
   snap_type snap;
   logic     snap_ready;

   utm_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   utm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .cfg        (cfg),
      .snap       (snap),
      .snap_ready (snap_ready)
   );

   utm_show u_show (
      .clock      (clock),
      .reset      (reset),
      .snap       (snap),
      .snap_ready (snap_ready),
      .cfg        (cfg),
      .rsp_chan   (rsp_chan)
   );

endmodule
